// ===== hw/rtl/qewm_pkg.sv =====
// Shared constants, types and the sine function for the QAM eye width monitor
`default_nettype none
package qewm_pkg;

	localparam int unsigned TIMESTEPS_DEF = 64;
	localparam int unsigned SYM_W         = 4;
	localparam int unsigned LVL_W         = 16;
	localparam int unsigned EYE_W         = 7;
	localparam int unsigned TOTAL_W       = 32;
	localparam int unsigned CFG_IDX_W     = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_PEAK_LEVEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MID_LEVEL  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QAM16_MODE = 2'd2;

	localparam logic [LVL_W-1:0] PEAK_RESET  = 16'd51200;
	localparam logic [LVL_W-1:0] MID_RESET   = 16'd17067;
	localparam logic [EYE_W-1:0] RUN_CAP     = 7'd127;

	localparam longint unsigned HALF_TURN    = 64'd65536;
	localparam longint unsigned QUARTER_TURN = 64'd32768;
	localparam longint unsigned PI_Q30       = 64'd3373259426;
	localparam longint unsigned ONE_Q30      = 64'd1073741824;

	typedef struct packed {
		logic start;
		logic issue;
		logic commit;
	} qewm_cmd_t;

	typedef struct packed {
		logic last_sample;
		logic out_free;
	} qewm_stat_t;

	// sin(q*pi/65536) in unsigned Q0.15 for q in 0..32768, clamped to 32767
	function automatic logic [14:0] sine_q15(input longint unsigned q_in);
		longint unsigned q;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned r;
		q  = (q_in > QUARTER_TURN) ? QUARTER_TURN : q_in;
		x  = (q * PI_Q30) >> 16;
		x2 = (x * x) >> 30;
		t  = ONE_Q30;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
		s  = (x * t) >> 30;
		r  = (s + 64'd16384) >> 15;
		if (r > 64'd32767) begin
			r = 64'd32767;
		end
		return r[14:0];
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/qewm_if.sv =====
// Valid/ready channel interfaces for symbols in and eye results out
`default_nettype none
interface qewm_sym_if
	import qewm_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;

	modport source (output valid, output symbol, input ready);
	modport sink   (input valid, input symbol, output ready);
endinterface

interface qewm_res_if
	import qewm_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [EYE_W-1:0]   eye_steps;
	logic [EYE_W-1:0]   min_eye_steps;
	logic [EYE_W-1:0]   max_eye_steps;
	logic [TOTAL_W-1:0] total_eye_steps;

	modport source (output valid, output eye_steps, output min_eye_steps,
		output max_eye_steps, output total_eye_steps, input ready);
	modport sink   (input valid, input eye_steps, input min_eye_steps,
		input max_eye_steps, input total_eye_steps, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/qam_eye_width_monitor.sv =====
// QAM eye width monitor: per-symbol eye run with running min, max and total
//
// Usage:
//   sym_in  : one 4-bit QAM symbol per transaction (valid/ready).
//   res_out : one result per symbol: eye_steps, min_eye_steps, max_eye_steps,
//             total_eye_steps (valid/ready).
//   cfg_we/cfg_index/cfg_data: write peak_level (0), mid_level (1),
//             qam16_mode (2); write only while no symbol is in flight.
// Timing: the sample sweep issues one
//   waveform sample per cycle from the sine table through one product
//   stage into the run tracker, then, after a drain state, the statistics
//   commit into the output register. The next symbol is taken only after
//   that commit, in the cycle in which the result becomes valid.
// Reset: registers return to peak 51200, mid 17067, 16-QAM; previous Q level
//   is +51200, min 127, max 0, total 0; the output register is empty.
// Stall: a result held in the output register stalls the commit of the next
//   symbol, which then waits with its sweep finished; nothing is dropped.
`default_nettype none
module qam_eye_width_monitor
	import qewm_pkg::*;
#(
	parameter int unsigned TIMESTEPS = TIMESTEPS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [LVL_W-1:0]     cfg_data,
	qewm_sym_if.sink                  sym_in,
	qewm_res_if.source                res_out
);

	qewm_cmd_t  cmd;
	qewm_stat_t stat;

	qewm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sym_in.valid),
		.in_ready (sym_in.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	qewm_dp #(
		.TIMESTEPS (TIMESTEPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.symbol    (sym_in.symbol),
		.cmd       (cmd),
		.stat      (stat),
		.res       (res_out)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/qewm_ctrl.sv =====
// Controller state machine: accept a symbol, sweep samples, drain, commit result
`default_nettype none
module qewm_ctrl
	import qewm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire qewm_stat_t stat,
	output qewm_cmd_t       cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_RUN   = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		in_ready   = (state_q == S_IDLE);
		cmd.start  = in_ready && in_valid;
		cmd.issue  = (state_q == S_RUN);
		cmd.commit = (state_q == S_DONE) && stat.out_free;
		state_nxt  = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = S_RUN;
				end
			end
			S_RUN: begin
				if (stat.last_sample) begin
					state_nxt = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/qewm_dp.sv =====
// Datapath: registers, sine table, waveform products, run tracking and statistics
`default_nettype none
module qewm_dp
	import qewm_pkg::*;
#(
	parameter int unsigned TIMESTEPS = TIMESTEPS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [LVL_W-1:0]     cfg_data,
	input  wire logic [SYM_W-1:0]     symbol,
	input  wire qewm_cmd_t            cmd,
	output qewm_stat_t                stat,
	qewm_res_if.source                res
);

	localparam int unsigned IDX_W  = $clog2(TIMESTEPS);
	localparam int unsigned RUN_W  = $clog2(TIMESTEPS + 1);
	localparam int unsigned HALF_N = TIMESTEPS / 2;
	localparam int unsigned WIDE_W = 34;

	logic [14:0] sin_rom [TIMESTEPS];
	logic [14:0] cos_rom [TIMESTEPS];
	logic        cneg_rom [TIMESTEPS];

	for (genvar g = 0; g < TIMESTEPS; g++) begin : g_rom
		localparam longint unsigned P = ((g + 1) * HALF_TURN) / TIMESTEPS;
		localparam longint unsigned SQ = (P <= QUARTER_TURN) ? P : HALF_TURN - P;
		localparam longint unsigned CQ =
			(P <= QUARTER_TURN) ? QUARTER_TURN - P : P - QUARTER_TURN;
		localparam logic [14:0] SV = sine_q15(SQ);
		localparam logic [14:0] CV = sine_q15(CQ);
		assign sin_rom[g]  = SV;
		assign cos_rom[g]  = CV;
		assign cneg_rom[g] = (P > QUARTER_TURN);
	end

	logic [LVL_W-1:0]         peak_q;
	logic [LVL_W-1:0]         mid_q;
	logic                     qam16_q;
	logic signed [17:0]       prev_q_q;
	logic signed [17:0]       i_lvl_q;
	logic signed [17:0]       q_lvl_q;
	logic signed [WIDE_W-1:0] lo_q;
	logic signed [WIDE_W-1:0] hi_q;
	logic                     no_lo_q;
	logic                     no_hi_q;
	logic [IDX_W-1:0]         idx_q;
	logic                     vld_s1;
	logic signed [WIDE_W-1:0] prod_i_s1;
	logic signed [WIDE_W-1:0] prod_q_s1;
	logic [RUN_W-1:0]         run_q;
	logic [RUN_W-1:0]         best_q;
	logic [EYE_W-1:0]         min_q;
	logic [EYE_W-1:0]         max_q;
	logic [TOTAL_W-1:0]       total_q;
	logic                     out_valid_q;
	logic [EYE_W-1:0]         eye_out_q;
	logic [EYE_W-1:0]         min_out_q;
	logic [EYE_W-1:0]         max_out_q;
	logic [TOTAL_W-1:0]       total_out_q;

	logic                     i_outer;
	logic                     q_outer;
	logic signed [17:0]       i_mag;
	logic signed [17:0]       q_mag;
	logic signed [17:0]       i_lvl;
	logic signed [17:0]       q_lvl;
	logic signed [17:0]       mid_s;
	logic signed [17:0]       lo_base;
	logic signed [17:0]       hi_base;
	logic signed [17:0]       qp;
	logic signed [15:0]       sv;
	logic signed [16:0]       cv;
	logic signed [WIDE_W-1:0] prod_i;
	logic signed [WIDE_W-1:0] prod_q;
	logic signed [WIDE_W-1:0] v;
	logic                     in_win;
	logic [RUN_W-1:0]         run_inc;
	logic [9:0]               best_x;
	logic [EYE_W-1:0]         shown;
	logic [TOTAL_W:0]         sum;
	logic [TOTAL_W-1:0]       total_nxt;

	always_comb begin
		i_outer = !qam16_q || symbol[2];
		q_outer = !qam16_q || symbol[3];
		i_mag   = signed'({2'b00, (i_outer ? peak_q : mid_q)});
		q_mag   = signed'({2'b00, (q_outer ? peak_q : mid_q)});
		i_lvl   = symbol[0] ? i_mag : -i_mag;
		q_lvl   = symbol[1] ? q_mag : -q_mag;
		mid_s   = signed'({2'b00, mid_q});
		lo_base = i_lvl - mid_s;
		hi_base = i_lvl + mid_s;

		qp = (32'(idx_q) < HALF_N) ? prev_q_q : -q_lvl_q;
		sv = signed'({1'b0, sin_rom[idx_q]});
		cv = cneg_rom[idx_q] ? -signed'({2'b00, cos_rom[idx_q]})
			: signed'({2'b00, cos_rom[idx_q]});
		prod_i = i_lvl_q * sv;
		prod_q = qp * cv;

		v       = prod_i_s1 + prod_q_s1;
		in_win  = (no_lo_q || (v > lo_q)) && (no_hi_q || (v < hi_q));
		run_inc = run_q + 1'b1;

		best_x    = 10'(best_q);
		shown     = (best_x > 10'(RUN_CAP)) ? RUN_CAP : best_x[EYE_W-1:0];
		sum       = {1'b0, total_q} + (TOTAL_W + 1)'(best_q);
		total_nxt = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

		stat.last_sample = (idx_q == IDX_W'(TIMESTEPS - 1));
		stat.out_free    = !out_valid_q || res.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q      <= PEAK_RESET;
			mid_q       <= MID_RESET;
			qam16_q     <= 1'b1;
			prev_q_q    <= signed'({2'b00, PEAK_RESET});
			min_q       <= RUN_CAP;
			max_q       <= '0;
			total_q     <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_PEAK_LEVEL: peak_q  <= cfg_data;
					CFG_MID_LEVEL:  mid_q   <= cfg_data;
					CFG_QAM16_MODE: qam16_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
			vld_s1 <= cmd.issue;
			if (cmd.commit) begin
				if (shown < min_q) begin
					min_q <= shown;
				end
				if (shown > max_q) begin
					max_q <= shown;
				end
				total_q     <= total_nxt;
				prev_q_q    <= q_lvl_q;
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			i_lvl_q <= i_lvl;
			q_lvl_q <= q_lvl;
			lo_q    <= WIDE_W'(lo_base) <<< 15;
			hi_q    <= WIDE_W'(hi_base) <<< 15;
			no_lo_q <= i_outer && !symbol[0];
			no_hi_q <= i_outer && symbol[0];
			idx_q   <= '0;
			run_q   <= '0;
			best_q  <= '0;
		end else begin
			if (cmd.issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (vld_s1) begin
				if (in_win) begin
					run_q <= run_inc;
					if (run_inc > best_q) begin
						best_q <= run_inc;
					end
				end else begin
					run_q <= '0;
				end
			end
		end
		prod_i_s1 <= prod_i;
		prod_q_s1 <= prod_q;
		if (cmd.commit) begin
			eye_out_q   <= shown;
			min_out_q   <= (shown < min_q) ? shown : min_q;
			max_out_q   <= (shown > max_q) ? shown : max_q;
			total_out_q <= total_nxt;
		end
	end

	assign res.valid           = out_valid_q;
	assign res.eye_steps       = eye_out_q;
	assign res.min_eye_steps   = min_out_q;
	assign res.max_eye_steps   = max_out_q;
	assign res.total_eye_steps = total_out_q;

endmodule
`default_nettype wire
